[rtl/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-character mapping for the Base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // ASCII '=' used for group padding
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // Characters that one byte produces, as handed from front to back
  typedef struct packed {
    logic [3:0][6:0] chars;     // characters in emission order, entry 0 first
    logic [1:0]      last_idx;  // index of the final character of this item
    logic            msg_end;   // item closes the message
  } job_t;

  // Map a 6-bit sextet to its RFC 4648 character
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] v7;
    logic [6:0] r;
    v7 = {1'b0, v};
    if (v7 < 7'd26) begin
      r = v7 + 7'd65;        // 'A'..'Z'
    end else if (v7 < 7'd52) begin
      r = v7 + 7'd71;        // 'a'..'z'
    end else if (v7 < 7'd62) begin
      r = v7 - 7'd4;         // '0'..'9'
    end else if (v7 == 7'd62) begin
      r = 7'h2B;             // '+'
    end else begin
      r = 7'h2F;             // '/'
    end
    return r;
  endfunction

endpackage

[rtl/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Byte stream to RFC 4648 Base64 character stream encoder.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready with data_byte and last_byte; last_byte
// marks the final byte of a message. Output channel: out_valid / out_ready
// with out_char (7-bit ASCII) and last_char on the final character of the
// encoded message, '=' padding included.
// Each byte yields one to four characters. A byte is taken and classified at
// once; its characters wait in a QUEUE_DEPTH-entry queue and the output stage
// hands out one character per cycle while the receiver is ready. The first
// character of a byte passes through the queue entry and the output register
// before it appears. Throughput is set by the output stage: a byte yields one
// to four characters (four characters per three bytes in a long message, plus
// padding at its end). Input is taken every cycle while the queue has room.
// Reset clears the group position, the queue and the output stage; no
// characters are pending afterwards. When the receiver stalls the current
// character holds, the queue fills, and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       last_char
);

  b64e_pkg::job_t front_job;
  b64e_pkg::job_t q_job;
  logic           push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // Accept an item whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .job       (front_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

[rtl/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// Tracks the position within the 3-byte group and the leftover bits, and
// turns each accepted byte into the one to four characters it completes.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output b64e_pkg::job_t  job
);

  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] leftover, leftover_next;

  // Classify the byte by group position and build its characters
  always_comb begin
    job           = '0;
    phase_next    = phase;
    leftover_next = leftover;
    case (phase)
      PH1: begin
        job.chars[0] = b64e_pkg::sextet_char({leftover[1:0], data_byte[7:4]});
        if (last_byte) begin
          job.chars[1]  = b64e_pkg::sextet_char({data_byte[3:0], 2'b00});
          job.chars[2]  = b64e_pkg::PAD_CHAR;
          job.last_idx  = 2'd2;
          job.msg_end   = 1'b1;
          phase_next    = PH0;
          leftover_next = '0;
        end else begin
          job.last_idx  = 2'd0;
          phase_next    = PH2;
          leftover_next = data_byte[3:0];
        end
      end
      PH2: begin
        job.chars[0]  = b64e_pkg::sextet_char({leftover, data_byte[7:6]});
        job.chars[1]  = b64e_pkg::sextet_char(data_byte[5:0]);
        job.last_idx  = 2'd1;
        job.msg_end   = last_byte;
        phase_next    = PH0;
        leftover_next = '0;
      end
      default: begin
        job.chars[0] = b64e_pkg::sextet_char(data_byte[7:2]);
        if (last_byte) begin
          job.chars[1]  = b64e_pkg::sextet_char({data_byte[1:0], 4'b0000});
          job.chars[2]  = b64e_pkg::PAD_CHAR;
          job.chars[3]  = b64e_pkg::PAD_CHAR;
          job.last_idx  = 2'd3;
          job.msg_end   = 1'b1;
          phase_next    = PH0;
          leftover_next = '0;
        end else begin
          job.last_idx  = 2'd0;
          phase_next    = PH1;
          leftover_next = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  // Advance group state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH0;
      leftover <= '0;
    end else if (push) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

[rtl/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of character jobs between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64e_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output b64e_pkg::job_t  pop_job,
  output logic            empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b64e_pkg::job_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rd_ptr];

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

[rtl/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// Takes character jobs from the queue and hands them out one character
// per cycle while out_ready holds, marking each message's final character.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  b64e_pkg::job_t  q_job,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [6:0]      out_char,
  output logic            last_char
);

  b64e_pkg::job_t cur;
  logic           busy;
  logic [1:0]     idx;
  logic           fin;

  // Finish the current job when its final character is taken
  assign fin   = busy && out_ready && (idx == cur.last_idx);
  assign q_pop = !q_empty && (!busy || fin);

  assign out_valid = busy;
  assign out_char  = cur.chars[idx];
  assign last_char = cur.msg_end && (idx == cur.last_idx);

  // Hold the job being emitted
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  // Step through characters, load the next job back to back
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fin) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (busy && out_ready) begin
      idx <= idx + 1'b1;
    end
  end

  // Character index never runs past the job, end mark only on final character
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= cur.last_idx))
    else $error("character index beyond job");
  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    (busy && !fin) |-> !q_pop)
    else $error("job loaded while previous still emitting");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(last_char)))
    else $error("output item changed while stalled");

endmodule
